// ----- src/dssm_pkg.sv -----
// ----------------------------------------------------------------------------
// dssm_pkg: shared types and constants for the dual stack memory unit
// Holds the memory geometry, the operation and status codes, and the request
// and response beat layouts.
// ----------------------------------------------------------------------------
package dssm_pkg;

  // Memory geometry
  localparam int DEPTH    = 1024;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Counts run from zero to DEPTH inclusive
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CNT_OUT_W = 11;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic               side;
    logic signed [31:0] value;
  } req_beat_t;

  typedef struct packed {
    logic signed [31:0]     top_value;
    status_t                status;
    logic [CNT_OUT_W-1:0]   count_low;
    logic [CNT_OUT_W-1:0]   count_high;
  } rsp_beat_t;

endpackage

// ----- src/dssm_ram.sv -----
// ----------------------------------------------------------------------------
// dssm_ram: single-port synchronous RAM
// One access per cycle at one address; write or registered read.
// ----------------------------------------------------------------------------
module dssm_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, registered; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- src/dual_stack_shared_memory_unit.sv -----
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_unit: two stacks in one shared word memory
// The lower stack grows up from slot zero, the upper stack grows down from
// the last slot. Each request beat pushes, pops or peeks one stack.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req (req_beat_t)
//   rsp      out        rsp_valid / rsp_ready  rsp (rsp_beat_t)
//
// Push, pop, unused kinds and empty peeks load the response register directly;
// a non-empty peek loads it from the registered memory read data in S_READ.
// A request is taken in S_IDLE while the response register is empty or being drained.
// Reset clears both stack counts and the response valid flag; memory contents
// are left as they are and are only read after a push has written them.
// A stalled response holds the unit in place until it is taken.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  dssm_pkg::req_beat_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output dssm_pkg::rsp_beat_t rsp
);

  localparam int CNT_W  = dssm_pkg::CNT_W;
  localparam int ADDR_W = dssm_pkg::ADDR_W;

  dssm_pkg::state_t    state, state_next;
  logic [CNT_W-1:0]    lower_count, lower_count_next;
  logic [CNT_W-1:0]    upper_count, upper_count_next;
  dssm_pkg::rsp_beat_t rsp_next;
  logic                rsp_valid_next;

  logic                     mem_we;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_addr;
  logic [dssm_pkg::DATA_W-1:0] mem_rdata;

  logic                req_fire;
  logic [CNT_W-1:0]    side_count;
  logic [CNT_W:0]      total_count;
  logic [CNT_W-1:0]    push_slot;
  logic [CNT_W-1:0]    peek_slot;

  assign req_fire    = req_valid && req_ready;
  assign side_count  = req.side ? upper_count : lower_count;
  assign total_count = {1'b0, lower_count} + {1'b0, upper_count};
  // Slot of the next free word and of the current top word
  assign push_slot   = req.side ? (CNT_W'(dssm_pkg::DEPTH - 1) - upper_count) : lower_count;
  assign peek_slot   = req.side ? (CNT_W'(dssm_pkg::DEPTH) - upper_count)
                                : (lower_count - CNT_W'(1));

  dssm_ram #(
    .DATA_W (dssm_pkg::DATA_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (dssm_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (req.value),
    .rdata (mem_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dssm_pkg::S_IDLE;
      lower_count <= '0;
      upper_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  // Decode the request, update counts, drive the memory port
  always_comb begin
    state_next       = state;
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = ADDR_W'(push_slot);
    req_ready        = (state == dssm_pkg::S_IDLE) && (!rsp_valid || rsp_ready);

    case (state)
      dssm_pkg::S_IDLE: begin
        if (req_fire) begin
          rsp_next.top_value = '0;
          rsp_next.status    = dssm_pkg::ST_OK;
          case (req.kind)
            dssm_pkg::KIND_PUSH: begin
              if (total_count >= (CNT_W+1)'(dssm_pkg::DEPTH)) begin
                rsp_next.status = dssm_pkg::ST_OVER;
              end else begin
                mem_we = 1'b1;
                if (req.side) begin
                  upper_count_next = upper_count + CNT_W'(1);
                end else begin
                  lower_count_next = lower_count + CNT_W'(1);
                end
              end
            end
            dssm_pkg::KIND_POP: begin
              if (side_count == '0) begin
                rsp_next.status = dssm_pkg::ST_UNDER;
              end else if (req.side) begin
                upper_count_next = upper_count - CNT_W'(1);
              end else begin
                lower_count_next = lower_count - CNT_W'(1);
              end
            end
            dssm_pkg::KIND_PEEK: begin
              if (side_count == '0) begin
                rsp_next.status = dssm_pkg::ST_UNDER;
              end else begin
                mem_re   = 1'b1;
                mem_addr = ADDR_W'(peek_slot);
              end
            end
            default: begin
            end
          endcase
          rsp_next.count_low  = dssm_pkg::CNT_OUT_W'(lower_count_next);
          rsp_next.count_high = dssm_pkg::CNT_OUT_W'(upper_count_next);
          // Hold the response back while a peek read is in flight
          if (mem_re) begin
            state_next     = dssm_pkg::S_READ;
            rsp_valid_next = 1'b0;
          end else begin
            rsp_valid_next = 1'b1;
          end
        end
      end
      dssm_pkg::S_READ: begin
        rsp_next.top_value = mem_rdata;
        rsp_valid_next     = 1'b1;
        state_next         = dssm_pkg::S_IDLE;
      end
      default: begin
        state_next = dssm_pkg::S_IDLE;
      end
    endcase
  end

  // The two stacks never hold more than the memory
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_count <= (CNT_W+1)'(dssm_pkg::DEPTH))
    else $error("stack counts exceed memory depth");

  // No response is shown and no request is taken while a peek read is pending
  a_read_no_rsp: assert property (@(posedge clk) disable iff (rst)
    state == dssm_pkg::S_READ |-> !rsp_valid && !req_ready)
    else $error("response or request taken during peek read");

  // A peek read always completes into the response register
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == dssm_pkg::S_READ |=> state == dssm_pkg::S_IDLE && rsp_valid)
    else $error("peek read did not complete");

  // A pop of a non-empty lower stack drops its count by one
  a_pop_low: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind == dssm_pkg::KIND_POP && !req.side && lower_count != '0
    |=> lower_count == $past(lower_count) - CNT_W'(1))
    else $error("lower pop count mismatch");

  // A push on a full memory leaves both counts alone
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.kind == dssm_pkg::KIND_PUSH
    && total_count >= (CNT_W+1)'(dssm_pkg::DEPTH)
    |=> $stable(lower_count) && $stable(upper_count))
    else $error("push on full memory changed counts");

endmodule
